>>> design/sqvs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and helper functions of the sprite quad setup block.
// No dependencies; imported by sqvs_div and sprite_quad_vertex_setup.
package sqvs_pkg;

    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_VIEWPORT_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIEWPORT_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_WIDTH   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXTURE_HEIGHT  = 4'd3;

    localparam logic [13:0] RESET_VIEWPORT_WIDTH  = 14'd1920;
    localparam logic [13:0] RESET_VIEWPORT_HEIGHT = 14'd1080;
    localparam logic [13:0] RESET_TEXTURE_WIDTH   = 14'd256;
    localparam logic [13:0] RESET_TEXTURE_HEIGHT  = 14'd256;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Quotient bits kept by every divider; larger quotients all saturate.
    localparam int QUO_W = 16;

    // Taylor series of sine to x^11 in Q30, rounded to Q14. Elaboration only.
    function automatic logic [14:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return 15'((s + (64'd1 << 15)) >> 16);
    endfunction

    function automatic logic [13:0] nonzero(input logic [13:0] r);
        return (r == 14'd0) ? 14'd1 : r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

endpackage

>>> design/sprite_quad_vertex_setup.sv
`timescale 1ns / 1ps
// Top level of the rotated sprite quad setup block.
// Depends on sqvs_pkg and sqvs_div.
//
// Usage:
//   One sprite request is an item on the input channel (in_valid / in_ready).
//   It yields four vertex items on the output channel (out_valid / out_ready)
//   in strip order: top-left, bottom-left, top-right, bottom-right, the last
//   one flagged by last_corner.
//   A sprite register splits each request into one corner per cycle while the
//   output is not stalled, so a new request is taken only as the held sprite
//   issues its last corner. The corner pipeline itself accepts a corner in
//   every cycle unless the output stalls. From acceptance, a corner passes
//   the sprite register (loaded at the accepting edge), angle index, sine
//   table read, products, sums, magnitude, 17 divider stages (an overflow
//   check, then one quotient bit each) and the output register. The four
//   registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while the block is idle; the block does not enforce
//   it. A zero register acts as one. Reset empties the pipeline and loads
//   the default viewport and texture sizes; no clearing pass is needed.
//   When the receiver stalls, the whole corner pipeline holds; the sprite
//   register holds its corner count, and in_ready drops once the held
//   sprite still has corners to issue.
module sprite_quad_vertex_setup
    import sqvs_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [13:0]            cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     dst_x,
    input  logic signed [15:0]     dst_y,
    input  logic signed [15:0]     dst_w,
    input  logic signed [15:0]     dst_h,
    input  logic [15:0]            rotation_angle,
    input  logic [16:0]            src_x,
    input  logic [16:0]            src_y,
    input  logic [16:0]            src_w,
    input  logic [16:0]            src_h,
    input  logic [31:0]            color_in,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     pos_x,
    output logic signed [15:0]     pos_y,
    output logic signed [15:0]     tex_u,
    output logic signed [15:0]     tex_v,
    output logic [31:0]            color_out,
    output logic [1:0]             corner_index,
    output logic                   last_corner
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 14 + IW + 1;
    localparam int QW = QUO_W;

    // ------------------------------------------------------------------
    // Quarter-wave sine table, built at elaboration.
    // ------------------------------------------------------------------
    logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] XQ = (64'(g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        assign sine_rom[g] = quarter_sine(XQ);
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [13:0] vp_w_reg;
    logic [13:0] vp_h_reg;
    logic [13:0] tex_w_reg;
    logic [13:0] tex_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_w_reg  <= RESET_VIEWPORT_WIDTH;
            vp_h_reg  <= RESET_VIEWPORT_HEIGHT;
            tex_w_reg <= RESET_TEXTURE_WIDTH;
            tex_h_reg <= RESET_TEXTURE_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VIEWPORT_WIDTH:  vp_w_reg  <= cfg_data;
                CFG_VIEWPORT_HEIGHT: vp_h_reg  <= cfg_data;
                CFG_TEXTURE_WIDTH:   tex_w_reg <= cfg_data;
                CFG_TEXTURE_HEIGHT:  tex_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Divisors: 16*W and 16*H for positions, texW and texH for UV.
    logic [17:0] div_x;
    logic [17:0] div_y;
    logic [13:0] div_u;
    logic [13:0] div_v;

    assign div_x = {nonzero(vp_w_reg), 4'b0000};
    assign div_y = {nonzero(vp_h_reg), 4'b0000};
    assign div_u = nonzero(tex_w_reg);
    assign div_v = nonzero(tex_h_reg);

    // ------------------------------------------------------------------
    // Pipeline advance: the whole corner pipeline moves unless the output
    // register is full and stalled.
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Sprite register and corner counter.
    // ------------------------------------------------------------------
    logic               busy_reg;
    logic [1:0]         cnt_reg;
    logic signed [15:0] sp_dx_reg;
    logic signed [15:0] sp_dy_reg;
    logic signed [15:0] sp_dw_reg;
    logic signed [15:0] sp_dh_reg;
    logic [15:0]        sp_ang_reg;
    logic [16:0]        sp_sx_reg;
    logic [16:0]        sp_sy_reg;
    logic [16:0]        sp_sw_reg;
    logic [16:0]        sp_sh_reg;
    logic [31:0]        sp_col_reg;

    logic in_accept;
    logic issue;

    assign in_ready  = !busy_reg || (cnt_reg == 2'd3 && en);
    assign in_accept = in_valid && in_ready;
    assign issue     = busy_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (in_accept)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd0;
        end
        else if (issue)
        begin
            busy_reg <= (cnt_reg != 2'd3);
            cnt_reg  <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sp_dx_reg  <= dst_x;
            sp_dy_reg  <= dst_y;
            sp_dw_reg  <= dst_w;
            sp_dh_reg  <= dst_h;
            sp_ang_reg <= rotation_angle;
            sp_sx_reg  <= src_x;
            sp_sy_reg  <= src_y;
            sp_sw_reg  <= src_w;
            sp_sh_reg  <= src_h;
            sp_col_reg <= color_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: corner offsets, centre, texture coordinates, table indexes.
    // Corner bits: right is the high bit of the slot, bottom the low bit.
    // ------------------------------------------------------------------
    logic          right;
    logic          bottom;
    logic [15:0]   cos_ang;
    logic [PW-1:0] sin_prod;
    logic [PW-1:0] cos_prod;
    logic [IW-1:0] sin_i;
    logic [IW-1:0] cos_i;

    assign right    = cnt_reg[1];
    assign bottom   = cnt_reg[0];
    assign cos_ang  = sp_ang_reg + 16'd16384;
    assign sin_prod = PW'(sp_ang_reg[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
    assign cos_prod = PW'(cos_ang[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(8192);
    assign sin_i    = IW'(sin_prod >> 14);
    assign cos_i    = IW'(cos_prod >> 14);

    logic               s1_valid_reg;
    logic [IW-1:0]      s1_ks_reg;
    logic [IW-1:0]      s1_kc_reg;
    logic               s1_ns_reg;
    logic               s1_nc_reg;
    logic signed [16:0] s1_ox_reg;
    logic signed [16:0] s1_oy_reg;
    logic signed [17:0] s1_cx_reg;
    logic signed [17:0] s1_cy_reg;
    logic [17:0]        s1_s_reg;
    logic [17:0]        s1_t_reg;
    logic [31:0]        s1_col_reg;
    logic [1:0]         s1_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ks_reg  <= sp_ang_reg[14] ? IW'(SINE_TABLE_DEPTH) - sin_i : sin_i;
            s1_kc_reg  <= cos_ang[14] ? IW'(SINE_TABLE_DEPTH) - cos_i : cos_i;
            s1_ns_reg  <= sp_ang_reg[15];
            s1_nc_reg  <= cos_ang[15];
            s1_ox_reg  <= right  ? 17'(sp_dw_reg) : -17'(sp_dw_reg);
            s1_oy_reg  <= bottom ? 17'(sp_dh_reg) : -17'(sp_dh_reg);
            s1_cx_reg  <= (18'(sp_dx_reg) <<< 1) + 18'(sp_dw_reg);
            s1_cy_reg  <= (18'(sp_dy_reg) <<< 1) + 18'(sp_dh_reg);
            s1_s_reg   <= right  ? 18'(sp_sx_reg) + 18'(sp_sw_reg) : 18'(sp_sx_reg);
            s1_t_reg   <= bottom ? 18'(sp_sy_reg) + 18'(sp_sh_reg) : 18'(sp_sy_reg);
            s1_col_reg <= sp_col_reg;
            s1_cnt_reg <= cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sine table read, sign applied.
    // ------------------------------------------------------------------
    logic [14:0] sin_mag;
    logic [14:0] cos_mag;

    assign sin_mag = sine_rom[s1_ks_reg];
    assign cos_mag = sine_rom[s1_kc_reg];

    logic               s2_valid_reg;
    logic signed [15:0] s2_sn_reg;
    logic signed [15:0] s2_cs_reg;
    logic signed [16:0] s2_ox_reg;
    logic signed [16:0] s2_oy_reg;
    logic signed [17:0] s2_cx_reg;
    logic signed [17:0] s2_cy_reg;
    logic [17:0]        s2_s_reg;
    logic [17:0]        s2_t_reg;
    logic [31:0]        s2_col_reg;
    logic [1:0]         s2_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sn_reg  <= s1_ns_reg ? -$signed(16'(sin_mag)) : $signed(16'(sin_mag));
            s2_cs_reg  <= s1_nc_reg ? -$signed(16'(cos_mag)) : $signed(16'(cos_mag));
            s2_ox_reg  <= s1_ox_reg;
            s2_oy_reg  <= s1_oy_reg;
            s2_cx_reg  <= s1_cx_reg;
            s2_cy_reg  <= s1_cy_reg;
            s2_s_reg   <= s1_s_reg;
            s2_t_reg   <= s1_t_reg;
            s2_col_reg <= s1_col_reg;
            s2_cnt_reg <= s1_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotation products.
    // ------------------------------------------------------------------
    logic               s3_valid_reg;
    logic signed [32:0] s3_cox_reg;
    logic signed [32:0] s3_soy_reg;
    logic signed [32:0] s3_sox_reg;
    logic signed [32:0] s3_coy_reg;
    logic signed [17:0] s3_cx_reg;
    logic signed [17:0] s3_cy_reg;
    logic [17:0]        s3_s_reg;
    logic [17:0]        s3_t_reg;
    logic [31:0]        s3_col_reg;
    logic [1:0]         s3_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_cox_reg <= 33'(s2_cs_reg) * 33'(s2_ox_reg);
            s3_soy_reg <= 33'(s2_sn_reg) * 33'(s2_oy_reg);
            s3_sox_reg <= 33'(s2_sn_reg) * 33'(s2_ox_reg);
            s3_coy_reg <= 33'(s2_cs_reg) * 33'(s2_oy_reg);
            s3_cx_reg  <= s2_cx_reg;
            s3_cy_reg  <= s2_cy_reg;
            s3_s_reg   <= s2_s_reg;
            s3_t_reg   <= s2_t_reg;
            s3_col_reg <= s2_col_reg;
            s3_cnt_reg <= s2_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rotated position in units of 2^-19 pixel.
    // ------------------------------------------------------------------
    logic               s4_valid_reg;
    logic signed [33:0] s4_x_reg;
    logic signed [33:0] s4_y_reg;
    logic [27:0]        s4_un_reg;
    logic [27:0]        s4_vn_reg;
    logic [31:0]        s4_col_reg;
    logic [1:0]         s4_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_x_reg   <= (34'(s3_cx_reg) <<< 14) + 34'(s3_cox_reg) - 34'(s3_soy_reg);
            s4_y_reg   <= (34'(s3_cy_reg) <<< 14) + 34'(s3_sox_reg) + 34'(s3_coy_reg);
            s4_un_reg  <= {s3_s_reg, 10'd0};
            s4_vn_reg  <= {s3_t_reg, 10'd0};
            s4_col_reg <= s3_col_reg;
            s4_cnt_reg <= s3_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sign and magnitude for the position dividers.
    // ------------------------------------------------------------------
    logic        s5_valid_reg;
    logic        s5_negx_reg;
    logic        s5_negy_reg;
    logic [33:0] s5_magx_reg;
    logic [33:0] s5_magy_reg;
    logic [27:0] s5_un_reg;
    logic [27:0] s5_vn_reg;
    logic [31:0] s5_col_reg;
    logic [1:0]  s5_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_negx_reg <= s4_x_reg[33];
            s5_negy_reg <= s4_y_reg[33];
            s5_magx_reg <= s4_x_reg[33] ? 34'(-s4_x_reg) : 34'(s4_x_reg);
            s5_magy_reg <= s4_y_reg[33] ? 34'(-s4_y_reg) : 34'(s4_y_reg);
            s5_un_reg   <= s4_un_reg;
            s5_vn_reg   <= s4_vn_reg;
            s5_col_reg  <= s4_col_reg;
            s5_cnt_reg  <= s4_cnt_reg;
        end
    end

    // ------------------------------------------------------------------
    // Dividers: round half away from zero by adding half the divisor to
    // the magnitude.
    // ------------------------------------------------------------------
    logic [33:0]   num_x;
    logic [33:0]   num_y;
    logic [28:0]   num_u;
    logic [28:0]   num_v;
    logic [QW-1:0] quo_x;
    logic [QW-1:0] quo_y;
    logic [QW-1:0] quo_u;
    logic [QW-1:0] quo_v;

    assign num_x = s5_magx_reg + 34'(div_x >> 1);
    assign num_y = s5_magy_reg + 34'(div_y >> 1);
    assign num_u = 29'(s5_un_reg) + 29'(div_u >> 1);
    assign num_v = 29'(s5_vn_reg) + 29'(div_v >> 1);

    sqvs_div #(.NW(34), .DW(18), .QW(QW)) u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (num_x),
        .den (div_x),
        .quo (quo_x)
    );

    sqvs_div #(.NW(34), .DW(18), .QW(QW)) u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (num_y),
        .den (div_y),
        .quo (quo_y)
    );

    sqvs_div #(.NW(29), .DW(14), .QW(QW)) u_div_u
    (
        .clk (clk),
        .en  (en),
        .num (num_u),
        .den (div_u),
        .quo (quo_u)
    );

    sqvs_div #(.NW(29), .DW(14), .QW(QW)) u_div_v
    (
        .clk (clk),
        .en  (en),
        .num (num_v),
        .den (div_v),
        .quo (quo_v)
    );

    // Side line alongside the divider stages.
    logic        dv_valid_reg [QW+1];
    logic        dv_negx_reg  [QW+1];
    logic        dv_negy_reg  [QW+1];
    logic [31:0] dv_col_reg   [QW+1];
    logic [1:0]  dv_cnt_reg   [QW+1];

    for (genvar j = 0; j <= QW; j++)
    begin : g_side
        logic        valid_prev;
        logic        negx_prev;
        logic        negy_prev;
        logic [31:0] col_prev;
        logic [1:0]  cnt_prev;

        if (j == 0)
        begin : g_first
            assign valid_prev = s5_valid_reg;
            assign negx_prev  = s5_negx_reg;
            assign negy_prev  = s5_negy_reg;
            assign col_prev   = s5_col_reg;
            assign cnt_prev   = s5_cnt_reg;
        end
        else
        begin : g_rest
            assign valid_prev = dv_valid_reg[j-1];
            assign negx_prev  = dv_negx_reg[j-1];
            assign negy_prev  = dv_negy_reg[j-1];
            assign col_prev   = dv_col_reg[j-1];
            assign cnt_prev   = dv_cnt_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_negx_reg[j] <= negx_prev;
                dv_negy_reg[j] <= negy_prev;
                dv_col_reg[j]  <= col_prev;
                dv_cnt_reg[j]  <= cnt_prev;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: NDC offset and saturation.
    // ------------------------------------------------------------------
    logic signed [17:0] qx_s;
    logic signed [17:0] qy_s;
    logic signed [17:0] px_next;
    logic signed [17:0] py_next;

    assign qx_s    = $signed(18'(quo_x));
    assign qy_s    = $signed(18'(quo_y));
    assign px_next = (dv_negx_reg[QW] ? -qx_s : qx_s) - 18'sd16384;
    assign py_next = 18'sd16384 - (dv_negy_reg[QW] ? -qy_s : qy_s);

    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] tex_u_reg;
    logic signed [15:0] tex_v_reg;
    logic [31:0]        col_out_reg;
    logic [1:0]         cnt_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg   <= sat16(px_next);
            pos_y_reg   <= sat16(py_next);
            tex_u_reg   <= sat16($signed(18'(quo_u)));
            tex_v_reg   <= sat16($signed(18'(quo_v)));
            col_out_reg <= dv_col_reg[QW];
            cnt_out_reg <= dv_cnt_reg[QW];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign color_out    = col_out_reg;
    assign corner_index = cnt_out_reg;
    assign last_corner  = (cnt_out_reg == 2'd3);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg && cnt_reg == 2'd0)
        else $error("accepted item did not start at the first corner");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 2'd0)
        else $error("corner count not at zero while idle");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s5_valid_reg) && $stable(dv_valid_reg[QW]))
        else $error("pipeline moved during a stall");

    a_uv_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !tex_u[15] && !tex_v[15])
        else $error("texture coordinate went negative");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && $past(en) |-> s1_cnt_reg == s2_cnt_reg + 2'd1)
        else $error("corners out of strip order");

endmodule

>>> design/sqvs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on sqvs_pkg (no items used beyond the import convention).
module sqvs_div
    import sqvs_pkg::*;
#(
    parameter int NW = 34,
    parameter int DW = 18,
    parameter int QW = 16
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [WW-1:0] rem_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          ovf_reg [QW+1];

    // Flag quotients that do not fit; the stages below then never overflow.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= WW'(num);
            q_reg[0]   <= '0;
            ovf_reg[0] <= WW'(num) >= (WW'(den) << QW);
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_stage
        localparam int B = QW - j;
        logic [WW-1:0] shifted;
        assign shifted = WW'(den) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ovf_reg[j] <= ovf_reg[j-1];
                if (rem_reg[j-1] >= shifted)
                begin
                    rem_reg[j] <= rem_reg[j-1] - shifted;
                    q_reg[j]   <= q_reg[j-1] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    assign quo = ovf_reg[QW] ? '1 : q_reg[QW];

endmodule
